>>> hdl/ycc440_pkg.sv
package ycc440_pkg;

  localparam int PixW    = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 13;
  localparam int IndexW  = 22;

  localparam int FrameWidthW  = 12;
  localparam int FrameHeightW = 13;

  localparam logic [FrameWidthW-1:0]  FrameWidthReset  = 12'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightReset = 13'd480;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_KEEP_LUMA    = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_t;

  localparam int SumW  = 24;
  localparam int ProdW = 38;
  localparam int QuoW  = ProdW - 28;

  localparam logic signed [SumW-1:0]  CoefYR  = 24'sd4899;
  localparam logic signed [SumW-1:0]  CoefYG  = 24'sd9617;
  localparam logic signed [SumW-1:0]  CoefYB  = 24'sd1868;
  localparam logic signed [ProdW-1:0] CoefCb  = 38'sd9257;
  localparam logic signed [ProdW-1:0] CoefCr  = 38'sd11682;
  localparam logic [PixW:0]           PixOffset = 9'd128;

endpackage

>>> hdl/ycc440_pix_if.sv
interface ycc440_pix_if
  import ycc440_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] blue;
  logic [PixW-1:0] green;
  logic [PixW-1:0] red;

  modport source (output valid, blue, green, red, input ready);
  modport sink (input valid, blue, green, red, output ready);
  modport monitor (input valid, ready, blue, green, red);
endinterface

>>> hdl/ycc440_out_if.sv
interface ycc440_out_if
  import ycc440_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [PixW-1:0] luma;
  logic                   luma_valid;
  logic signed [PixW-1:0] chroma_blue;
  logic signed [PixW-1:0] chroma_red;
  logic                   chroma_valid;
  logic [IndexW-1:0]      chroma_index;
  logic                   frame_end;

  modport source (output valid, luma, luma_valid, chroma_blue, chroma_red, chroma_valid,
                  chroma_index, frame_end, input ready);
  modport sink (input valid, luma, luma_valid, chroma_blue, chroma_red, chroma_valid,
                chroma_index, frame_end, output ready);
  modport monitor (input valid, ready, luma, luma_valid, chroma_blue, chroma_red,
                   chroma_valid, chroma_index, frame_end);
endinterface

>>> hdl/ycc440_cfg_if.sv
interface ycc440_cfg_if
  import ycc440_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

>>> hdl/rgb_to_ycbcr_440_subsample.sv
// RGB to YCbCr converter with 4:4:0 chroma subsampling.
// Channels: pixel (sink) takes one raster-order blue/green/red beat per pixel;
// result (source) gives one beat per pixel carrying luma, chroma of the row pair,
// the chroma plane index and frame_end; cfg (sink, always ready) writes
// frame_width, frame_height and keep_luma. The user must use it only while the block
// is idle; the block itself does not enforce this. Throughput: one pixel per cycle
// unless the receiver stalls, set by a six-stage pipeline with one valid bit per
// stage; the chroma line store has one port, read or written as a pixel enters
// stage five (even rows write, odd rows read the entry a row later).
// Chroma of even rows is held in the line store and averaged with the odd row;
// the final row of an odd-height frame passes its chroma through unaveraged.
// Reset (synchronous, rst high) empties the pipeline, clears the column and row
// counters and the plane base, and returns the registers to 640, 480 and 1.
// The line store is not cleared; it is always written before it is read.
// When the receiver stalls, the output stage holds its beat and each stage ahead
// fills in turn; pixel.ready falls only once every stage holds a beat.
module rgb_to_ycbcr_440_subsample
  import ycc440_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic           clk,
  input  logic           rst,
  ycc440_pix_if.sink     pixel,
  ycc440_out_if.source   result,
  ycc440_cfg_if.sink     cfg
);

  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WidW = $clog2(MAX_WIDTH + 1);
  localparam int RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HgtW = $clog2(MAX_HEIGHT + 1);

  typedef struct packed {
    logic              odd;
    logic              cvalid;
    logic [ColW-1:0]   slot;
    logic [IndexW-1:0] index;
    logic              fend;
    logic              keep;
  } ctl_t;

  // configuration registers
  logic [FrameWidthW-1:0]  frame_width;
  logic [FrameHeightW-1:0] frame_height;
  logic                    keep_luma;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FrameWidthReset;
      frame_height <= FrameHeightReset;
      keep_luma    <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_FRAME_WIDTH:  frame_width  <= cfg.data[FrameWidthW-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg.data[FrameHeightW-1:0];
        REG_KEEP_LUMA:    keep_luma    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic v1, v2, v3, v4, v5, v6;
  logic r1, r2, r3, r4, r5, r6;

  assign r6 = !v6 || result.ready;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign pixel.ready = r1;

  logic acc;
  assign acc = pixel.valid && r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (r1) v1 <= pixel.valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
    end
  end

  // raster position
  logic [ColW-1:0]   column_count, column_count_next;
  logic [RowW-1:0]   row_count, row_count_next;
  logic [IndexW-1:0] pair_base, pair_base_next;
  logic [WidW-1:0]   w_eff;
  logic [HgtW-1:0]   h_eff;
  logic              last_col, last_row;
  ctl_t              ctl_c;

  always_comb begin
    if (frame_width < FrameWidthW'(2)) begin
      w_eff = WidW'(2);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WidW'(MAX_WIDTH);
    end else begin
      w_eff = WidW'(frame_width);
    end
    if (frame_height < FrameHeightW'(1)) begin
      h_eff = HgtW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_eff = HgtW'(MAX_HEIGHT);
    end else begin
      h_eff = HgtW'(frame_height);
    end
  end

  assign last_col = (WidW'(column_count) + WidW'(1)) >= w_eff;
  assign last_row = (HgtW'(row_count) + HgtW'(1)) >= h_eff;

  always_comb begin
    column_count_next = column_count + ColW'(1);
    row_count_next    = row_count;
    pair_base_next    = pair_base;
    if (last_col) begin
      column_count_next = '0;
      if (last_row) begin
        row_count_next = '0;
        pair_base_next = '0;
      end else begin
        row_count_next = row_count + RowW'(1);
        if (row_count[0]) pair_base_next = pair_base + IndexW'(w_eff);
      end
    end
    ctl_c.odd    = row_count[0];
    ctl_c.cvalid = row_count[0] || last_row;
    ctl_c.slot   = column_count;
    ctl_c.index  = ctl_c.cvalid ? (pair_base + IndexW'(column_count)) : '0;
    ctl_c.fend   = last_col && last_row;
    ctl_c.keep   = keep_luma;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      pair_base    <= '0;
    end else if (acc) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      pair_base    <= pair_base_next;
    end
  end

  // stage 1: offset channels
  ctl_t                 c1, c2, c3, c4, c5;
  logic signed [PixW:0] b1, g1, r1_pix;

  always_ff @(posedge clk) begin
    if (acc) begin
      c1     <= ctl_c;
      b1     <= $signed({1'b0, pixel.blue} - PixOffset);
      g1     <= $signed({1'b0, pixel.green} - PixOffset);
      r1_pix <= $signed({1'b0, pixel.red} - PixOffset);
    end
  end

  // stage 2: luma sum
  logic signed [SumW-1:0] ysum2;
  logic signed [PixW:0]   b2, r2_pix;

  always_ff @(posedge clk) begin
    if (v1 && r2) begin
      c2     <= c1;
      ysum2  <= CoefYR * SumW'(r1_pix) + CoefYG * SumW'(g1) + CoefYB * SumW'(b1);
      b2     <= b1;
      r2_pix <= r1_pix;
    end
  end

  // stage 3: luma and chroma differences
  logic signed [SumW-1:0] ysum_adj;
  logic signed [PixW-1:0] y3, y4, y5, y6;
  logic signed [SumW-1:0] db3, dr3;

  assign ysum_adj = ysum2 + (ysum2[SumW-1] ? SumW'(16383) : SumW'(0));

  always_ff @(posedge clk) begin
    if (v2 && r3) begin
      c3  <= c2;
      y3  <= ysum_adj[14 +: PixW];
      db3 <= (SumW'(b2) <<< 14) - ysum2;
      dr3 <= (SumW'(r2_pix) <<< 14) - ysum2;
    end
  end

  // stage 4: chroma products
  logic signed [ProdW-1:0] pb4, pr4;

  always_ff @(posedge clk) begin
    if (v3 && r4) begin
      c4  <= c3;
      y4  <= y3;
      pb4 <= ProdW'(db3) * CoefCb;
      pr4 <= ProdW'(dr3) * CoefCr;
    end
  end

  // stage 5: scale, saturate, line store access
  function automatic logic signed [PixW-1:0] scale_sat(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] adj;
    logic signed [QuoW-1:0]  q;
    adj = p + (p[ProdW-1] ? ProdW'(28'hFFFFFFF) : ProdW'(0));
    q   = adj[ProdW-1:28];
    if (q > QuoW'(127)) begin
      scale_sat = 8'sd127;
    end else if (q < -QuoW'(128)) begin
      scale_sat = -8'sd128;
    end else begin
      scale_sat = q[PixW-1:0];
    end
  endfunction

  logic signed [PixW-1:0] cb_c, cr_c, cb5, cr5, cb_rd, cr_rd;
  logic                   load5;

  assign cb_c  = scale_sat(pb4);
  assign cr_c  = scale_sat(pr4);
  assign load5 = v4 && r5;

  logic signed [PixW-1:0] cb_line [MAX_WIDTH];
  logic signed [PixW-1:0] cr_line [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (load5) begin
      if (c4.odd) begin
        cb_rd <= cb_line[c4.slot];
        cr_rd <= cr_line[c4.slot];
      end else begin
        cb_line[c4.slot] <= cb_c;
        cr_line[c4.slot] <= cr_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load5) begin
      c5  <= c4;
      y5  <= y4;
      cb5 <= cb_c;
      cr5 <= cr_c;
    end
  end

  // stage 6: average and output register
  function automatic logic signed [PixW-1:0] avg2(input logic signed [PixW-1:0] a,
                                                 input logic signed [PixW-1:0] b);
    logic signed [PixW:0] s;
    s = (PixW+1)'(a) + (PixW+1)'(b);
    s = s + (PixW+1)'(s[PixW]);
    avg2 = s[PixW:1];
  endfunction

  logic signed [PixW-1:0] cb6, cr6;
  logic                   lv6, cv6, fe6;
  logic [IndexW-1:0]      idx6;

  always_ff @(posedge clk) begin
    if (v5 && r6) begin
      y6   <= c5.keep ? y5 : '0;
      lv6  <= c5.keep;
      cv6  <= c5.cvalid;
      idx6 <= c5.index;
      fe6  <= c5.fend;
      if (c5.odd) begin
        cb6 <= avg2(cb_rd, cb5);
        cr6 <= avg2(cr_rd, cr5);
      end else if (c5.cvalid) begin
        cb6 <= cb5;
        cr6 <= cr5;
      end else begin
        cb6 <= '0;
        cr6 <= '0;
      end
    end
  end

  assign result.valid        = v6;
  assign result.luma         = y6;
  assign result.luma_valid   = lv6;
  assign result.chroma_blue  = cb6;
  assign result.chroma_red   = cr6;
  assign result.chroma_valid = cv6;
  assign result.chroma_index = idx6;
  assign result.frame_end    = fe6;

endmodule

>>> hdl/ycc440_chk.sv
module ycc440_chk
  import ycc440_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              valid,
  input logic              ready,
  input logic [PixW-1:0]   luma,
  input logic              luma_valid,
  input logic [PixW-1:0]   chroma_blue,
  input logic [PixW-1:0]   chroma_red,
  input logic              chroma_valid,
  input logic [IndexW-1:0] chroma_index,
  input logic              frame_end
);

  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && !chroma_valid) |->
      (chroma_blue == '0 && chroma_red == '0 && chroma_index == '0))
    else $error("chroma fields nonzero without chroma_valid");

  a_luma_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && !luma_valid) |-> (luma == '0))
    else $error("luma nonzero without luma_valid");

  a_fend_chroma: assert property (@(posedge clk) disable iff (rst)
    (valid && frame_end) |-> chroma_valid)
    else $error("frame end beat lacks chroma");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !valid)
    else $error("result beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && !ready) |=> (valid && $stable(chroma_index)))
    else $error("stalled result beat dropped or changed");

endmodule

bind rgb_to_ycbcr_440_subsample ycc440_chk u_ycc440_chk (
  .clk          (clk),
  .rst          (rst),
  .valid        (result.valid),
  .ready        (result.ready),
  .luma         (result.luma),
  .luma_valid   (result.luma_valid),
  .chroma_blue  (result.chroma_blue),
  .chroma_red   (result.chroma_red),
  .chroma_valid (result.chroma_valid),
  .chroma_index (result.chroma_index),
  .frame_end    (result.frame_end)
);

>>> tb/sv/rgb_to_ycbcr_440_subsample_tb.sv
module rgb_to_ycbcr_440_subsample_tb;
  import ycc440_pkg::*;

  localparam int LineDepth   = 2048;
  localparam int MaxRows     = 4096;
  localparam int FlushCycles = 12;
  localparam int LongHold    = 64;
  localparam int RandomItems = 940;
  localparam int TimeLimit   = 20_000_000;

  localparam int     LumaR   = 4899;
  localparam int     LumaG   = 9617;
  localparam int     LumaB   = 1868;
  localparam longint CbGain  = 9257;
  localparam longint CrGain  = 11682;
  localparam longint QShift  = 268435456;

  typedef struct packed {
    logic [PixW-1:0] blue;
    logic [PixW-1:0] green;
    logic [PixW-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [PixW-1:0]   luma;
    logic              luma_valid;
    logic [PixW-1:0]   chroma_blue;
    logic [PixW-1:0]   chroma_red;
    logic              chroma_valid;
    logic [IndexW-1:0] chroma_index;
    logic              frame_end;
  } ycc_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ycc440_pix_if pix_if ();
  ycc440_out_if res_if ();
  ycc440_cfg_if cfg_if ();

  rgb_to_ycbcr_440_subsample u_dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pixel_t    pixel_q [$];
  ycc_beat_t ycc_expected [$];

  int items_sent, items_taken, chroma_beats, frames_seen, regs_written, errors;
  int holds_asked, holds_done, tx_gap, rx_gap, hold_left;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  logic [FrameWidthW-1:0]  reg_width  = FrameWidthReset;
  logic [FrameHeightW-1:0] reg_height = FrameHeightReset;
  logic                    reg_keep   = 1'b1;
  logic [PixW-1:0]         cb_row [LineDepth];
  logic [PixW-1:0]         cr_row [LineDepth];
  int                      col_cnt, row_cnt;
  logic [IndexW-1:0]       plane_base = '0;

  function automatic int eff_width();
    int w;
    w = int'(reg_width);
    if (w < 2) w = 2;
    if (w > LineDepth) w = LineDepth;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = int'(reg_height);
    if (h < 1) h = 1;
    if (h > MaxRows) h = MaxRows;
    return h;
  endfunction

  function automatic int chroma_term(int chan, int ysum, longint gain);
    longint q;
    q = (gain * (longint'(chan) * 16384 - longint'(ysum))) / QShift;
    if (q > 127) return 127;
    if (q < -128) return -128;
    return int'(q);
  endfunction

  function automatic ycc_beat_t convert_pixel(logic [PixW-1:0] b8, logic [PixW-1:0] g8,
                                              logic [PixW-1:0] r8);
    ycc_beat_t o;
    int b, g, r, ysum, y, cb, cr, w, h, slot, ocb, ocr;
    bit last_col, last_row, cvalid;
    w = eff_width();
    h = eff_height();
    b = int'(b8) - 128;
    g = int'(g8) - 128;
    r = int'(r8) - 128;
    ysum = LumaR * r + LumaG * g + LumaB * b;
    y = ysum / 16384;
    cb = chroma_term(b, ysum, CbGain);
    cr = chroma_term(r, ysum, CrGain);
    slot = (col_cnt < LineDepth) ? col_cnt : 0;
    last_col = (col_cnt + 1 >= w);
    last_row = (row_cnt + 1 >= h);
    cvalid = 1'b0;
    ocb = 0;
    ocr = 0;
    if (row_cnt[0]) begin
      ocb = (int'($signed(cb_row[slot])) + cb) / 2;
      ocr = (int'($signed(cr_row[slot])) + cr) / 2;
      cvalid = 1'b1;
    end else begin
      cb_row[slot] = cb[PixW-1:0];
      cr_row[slot] = cr[PixW-1:0];
      if (last_row) begin
        ocb = cb;
        ocr = cr;
        cvalid = 1'b1;
      end
    end
    o.luma         = reg_keep ? y[PixW-1:0] : '0;
    o.luma_valid   = reg_keep;
    o.chroma_blue  = ocb[PixW-1:0];
    o.chroma_red   = ocr[PixW-1:0];
    o.chroma_valid = cvalid;
    o.chroma_index = cvalid ? plane_base + col_cnt[IndexW-1:0] : '0;
    o.frame_end    = last_col && last_row;
    if (last_col) begin
      col_cnt = 0;
      if (last_row) begin
        row_cnt = 0;
        plane_base = '0;
      end else begin
        if (row_cnt[0]) plane_base = plane_base + w[IndexW-1:0];
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end
    return o;
  endfunction

  function automatic int frame_left();
    int w, h, cols, rows;
    w = eff_width();
    h = eff_height();
    cols = (col_cnt + 1 >= w) ? 1 : w - col_cnt;
    rows = (row_cnt + 1 >= h) ? 0 : h - row_cnt - 1;
    return cols + rows * w;
  endfunction

  function automatic int idle_len(bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [PixW-1:0] pick_channel();
    case ($urandom_range(0, 19))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h7f;
      3: return 8'h80;
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CfgDatW-1:0] pick_width();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return CfgDatW'($urandom_range(2, 12));
    if (roll < 88) return CfgDatW'($urandom_range(13, 64));
    if (roll < 94) return CfgDatW'($urandom_range(0, 1));
    return CfgDatW'($urandom_range(2049, 4095));
  endfunction

  function automatic logic [CfgDatW-1:0] pick_height();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return CfgDatW'($urandom_range(1, 8));
    if (roll < 85) return CfgDatW'(0);
    return CfgDatW'($urandom_range(9, 24));
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic push_pixel(logic [PixW-1:0] b, logic [PixW-1:0] g, logic [PixW-1:0] r);
    pixel_t px;
    px.blue  = b;
    px.green = g;
    px.red   = r;
    pixel_q.push_back(px);
    items_sent++;
  endtask

  task automatic push_random(int n);
    repeat (n) push_pixel(pick_channel(), pick_channel(), pick_channel());
  endtask

  task automatic drain();
    while (items_taken != items_sent || ycc_expected.size() != 0) @(posedge clk);
    repeat (FlushCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CfgDatW-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  reg_width  = val[FrameWidthW-1:0];
      REG_FRAME_HEIGHT: reg_height = val[FrameHeightW-1:0];
      REG_KEEP_LUMA:    reg_keep   = val[0];
      default: ;
    endcase
    regs_written++;
  endtask

  // hold the beat until taken, then idle or advance
  always @(posedge clk) begin
    if (rst) begin
      pix_if.valid <= 1'b0;
      tx_gap <= 0;
    end else if (!pix_if.valid || pix_if.ready) begin
      if (tx_gap > 0) begin
        pix_if.valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pixel_q.size() > 0) begin
        pix_if.valid <= 1'b1;
        pix_if.blue  <= pixel_q[0].blue;
        pix_if.green <= pixel_q[0].green;
        pix_if.red   <= pixel_q[0].red;
        void'(pixel_q.pop_front());
        tx_gap <= idle_len(tx_calm);
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_if.valid && pix_if.ready) begin
      ycc_expected.push_back(convert_pixel(pix_if.blue, pix_if.green, pix_if.red));
      items_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      rx_gap <= 0;
      hold_left <= 0;
      holds_done <= 0;
    end else if (holds_done != holds_asked) begin
      res_if.ready <= 1'b0;
      hold_left <= LongHold;
      holds_done <= holds_asked;
    end else if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (rx_gap > 0) begin
      res_if.ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      res_if.ready <= 1'b1;
      rx_gap <= idle_len(rx_calm);
    end
  end

  always @(posedge clk) begin
    ycc_beat_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (ycc_expected.size() == 0) begin
        $display("%0t: result beat with nothing expected, index %0h", $time,
                 res_if.chroma_index);
        errors++;
      end else begin
        want = ycc_expected.pop_front();
        check_field("luma", 32'(want.luma), 32'(res_if.luma[PixW-1:0]));
        check_field("luma_valid", 32'(want.luma_valid), 32'(res_if.luma_valid));
        check_field("chroma_blue", 32'(want.chroma_blue),
                    32'(res_if.chroma_blue[PixW-1:0]));
        check_field("chroma_red", 32'(want.chroma_red),
                    32'(res_if.chroma_red[PixW-1:0]));
        check_field("chroma_valid", 32'(want.chroma_valid), 32'(res_if.chroma_valid));
        check_field("chroma_index", 32'(want.chroma_index), 32'(res_if.chroma_index));
        check_field("frame_end", 32'(want.frame_end), 32'(res_if.frame_end));
      end
      if (res_if.chroma_valid) chroma_beats++;
      if (res_if.frame_end) frames_seen++;
    end
  end

  initial begin
    int rand_items, n, left;
    pix_if.valid = 1'b0;
    pix_if.blue  = '0;
    pix_if.green = '0;
    pix_if.red   = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_FRAME_WIDTH;
    cfg_if.data  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hff, 8'hff, 8'hff);
    drain();
    write_reg(REG_FRAME_WIDTH, 13'd1);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    write_reg(REG_KEEP_LUMA, 13'd1);
    push_pixel(8'hff, 8'h00, 8'h00);
    push_pixel(8'h00, 8'hff, 8'h00);
    push_pixel(8'h00, 8'h00, 8'hff);
    push_pixel(8'h00, 8'hff, 8'hff);
    push_pixel(8'hff, 8'hff, 8'h00);
    push_pixel(8'hff, 8'h00, 8'hff);
    push_pixel(8'h80, 8'h80, 8'h80);
    push_pixel(8'h7f, 8'h7f, 8'h7f);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hff, 8'hff, 8'hff);
    push_pixel(8'h01, 8'hfe, 8'h64);
    drain();
    write_reg(REG_KEEP_LUMA, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    push_random(4);
    drain();
    write_reg(REG_UNUSED, CfgDatW'($urandom));
    write_reg(REG_KEEP_LUMA, 13'h1fff);
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    push_random(6);

    drain();
    write_reg(REG_FRAME_WIDTH, 13'h1fff);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    write_reg(REG_KEEP_LUMA, CfgDatW'($urandom_range(0, 1)));
    push_random(16);

    drain();
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'h1fff);
    push_random(12);

    drain();
    tx_calm = 1'b1;
    rx_calm = 1'b0;
    holds_asked++;
    push_random(120);

    rand_items = 0;
    while (rand_items < RandomItems) begin
      drain();
      if (!row_cnt[0] && $urandom_range(0, 1)) write_reg(REG_FRAME_WIDTH, pick_width());
      if ($urandom_range(0, 1)) write_reg(REG_FRAME_HEIGHT, pick_height());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_KEEP_LUMA, CfgDatW'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, CfgDatW'($urandom));
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        tx_calm = 1'b1;
        holds_asked++;
      end
      left = frame_left();
      if (left <= 400 && $urandom_range(0, 9) < 7) n = left;
      else n = $urandom_range(1, 40);
      if (n > RandomItems - rand_items) n = RandomItems - rand_items;
      push_random(n);
      rand_items += n;
    end
    drain();

    $display("Run covered %0d pixels, %0d completed frames, %0d beats with chroma.",
             items_taken, frames_seen, chroma_beats);
    $display("Register writes: %0d, long receiver holds: %0d.", regs_written, holds_done);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(TimeLimit);
    $display("Timeout: %0d pixels sent, %0d taken, %0d results outstanding",
             items_sent, items_taken, ycc_expected.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
